FILE: hw/rtl/kal_pkg.sv
`default_nettype none

package kal_pkg;

	// Field widths
	localparam int MODE_W  = 2;
	localparam int NODE_W  = 10;
	localparam int STEPS_W = 11;

	// Table geometry
	localparam int MAX_NODES = 1024;
	localparam int LEVELS    = 11;
	localparam int LVL_W     = $clog2(LEVELS);
	localparam int TBL_DEPTH = LEVELS * MAX_NODES;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);

	// Register reset value and build range limit
	localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(1023);
	localparam logic [NODE_W-1:0] NODE_LAST_MAX  = NODE_W'(MAX_NODES - 1);

	// Lowest node whose table entries are stored; nodes below read as none
	localparam logic [NODE_W-1:0] FIRST_STORED = NODE_W'(2);

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD  = 2'd0,
		MODE_BUILD = 2'd1,
		MODE_QUERY = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_Q_STEP,
		S_Q_WAIT,
		S_Q_DONE,
		S_B_RD1,
		S_B_RD2,
		S_B_WR
	} state_t;

	typedef struct packed {
		logic [LVL_W-1:0]  level;
		logic [NODE_W-1:0] node;
	} tbl_rd_t;

	typedef struct packed {
		logic              en;
		logic [LVL_W-1:0]  level;
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] data;
	} tbl_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kal_if.sv
`default_nettype none

interface kal_req_if;
	import kal_pkg::*;

	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [NODE_W-1:0]  node;
	logic [NODE_W-1:0]  parent_node;
	logic [STEPS_W-1:0] steps;

	modport source (output valid, mode, node, parent_node, steps, input ready);
	modport sink   (input valid, mode, node, parent_node, steps, output ready);
endinterface

interface kal_rsp_if;
	import kal_pkg::*;

	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] ancestor;
	logic              found;

	modport source (output valid, ancestor, found, input ready);
	modport sink   (input valid, ancestor, found, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/kal_table.sv
`default_nettype none

module kal_table (
	input  wire logic                      clk,
	input  wire kal_pkg::tbl_wr_t          wr,
	input  wire kal_pkg::tbl_rd_t          rd,
	output logic [kal_pkg::NODE_W-1:0]     rd_data
);
	import kal_pkg::*;

	logic [NODE_W-1:0] mem [0:TBL_DEPTH-1];
	logic [TBL_AW-1:0] waddr;
	logic [TBL_AW-1:0] raddr;
	logic [NODE_W-1:0] rdata_s1;
	logic              rzero_s1;

	// Flatten level and node into one address
	assign waddr = TBL_AW'(wr.level) * TBL_AW'(MAX_NODES) + TBL_AW'(wr.node);
	assign raddr = TBL_AW'(rd.level) * TBL_AW'(MAX_NODES) + TBL_AW'(rd.node);

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[waddr] <= wr.data;
		end
	end

	// Registered read port; remember reads of node 0 and the root
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[raddr];
		rzero_s1 <= (rd.node < FIRST_STORED);
	end

	// Force none for node 0 and the root at every level
	assign rd_data = rzero_s1 ? '0 : rdata_s1;

endmodule

`default_nettype wire

FILE: hw/rtl/kth_ancestor_binary_lifting_unit.sv
// Query: each set step bit passes S_Q_STEP and S_Q_WAIT, each clear bit S_Q_STEP alone;
// the walk stops once it reaches node 0, and S_Q_DONE loads the result when the output
// register is free. Build: per node per level above 0, S_B_RD1, S_B_RD2 and S_B_WR in
// turn for nodes 1 to node_count, paced by the one read port of the jump table.
// Load writes the entry in idle. One transaction in work at a time, taken only in idle.
// Reset clears control state and sets node_count to 1023; the table is undefined.
`default_nettype none

module kth_ancestor_binary_lifting_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [kal_pkg::NODE_W-1:0] cfg_wdata,
	kal_req_if.sink                    req,
	kal_rsp_if.source                  rsp
);
	import kal_pkg::*;

	state_t             state_q, state_d;
	logic [LVL_W-1:0]   lvl_q, lvl_d;
	logic [NODE_W-1:0]  cur_q, cur_d;
	logic [STEPS_W-1:0] steps_q, steps_d;
	logic [NODE_W-1:0]  j_q, j_d;
	logic [NODE_W-1:0]  last_q, last_d;
	logic [NODE_W-1:0]  node_count_q;
	logic               out_valid_q, out_valid_d;
	logic [NODE_W-1:0]  ancestor_q, ancestor_d;
	logic               found_q, found_d;
	logic               steps_over;
	logic [NODE_W-1:0]  last_clip;
	tbl_rd_t            rd;
	tbl_wr_t            wr;
	logic [NODE_W-1:0]  rd_data;

	kal_table u_table (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	// Step counts with bits at or above LEVELS climb past any root
	assign steps_over = ((32'(req.steps) >> LEVELS) != 32'd0);
	assign last_clip  = (node_count_q > NODE_LAST_MAX) ? NODE_LAST_MAX : node_count_q;

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = out_valid_q;
	assign rsp.ancestor = ancestor_q;
	assign rsp.found    = found_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// State and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		lvl_q      <= lvl_d;
		cur_q      <= cur_d;
		steps_q    <= steps_d;
		j_q        <= j_d;
		last_q     <= last_d;
		ancestor_q <= ancestor_d;
		found_q    <= found_d;
	end

	// Sequencer
	always_comb begin
		state_d     = state_q;
		lvl_d       = lvl_q;
		cur_d       = cur_q;
		steps_d     = steps_q;
		j_d         = j_q;
		last_d      = last_q;
		ancestor_d  = ancestor_q;
		found_d     = found_q;
		out_valid_d = out_valid_q;
		rd.level    = lvl_q;
		rd.node     = cur_q;
		wr.en       = 1'b0;
		wr.level    = '0;
		wr.node     = req.node;
		wr.data     = req.parent_node;

		// Drop the result once taken
		if (rsp.valid && rsp.ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (mode_t'(req.mode))
						MODE_LOAD: begin
							wr.en = (req.node >= FIRST_STORED);
						end
						MODE_BUILD: begin
							lvl_d  = LVL_W'(1);
							j_d    = NODE_W'(1);
							last_d = last_clip;
							if (last_clip != '0) begin
								state_d = S_B_RD1;
							end
						end
						MODE_QUERY: begin
							lvl_d   = '0;
							steps_d = req.steps;
							cur_d   = steps_over ? '0 : req.node;
							state_d = S_Q_STEP;
						end
						default: begin
						end
					endcase
				end
			end
			S_Q_STEP: begin
				if (cur_q == '0) begin
					state_d = S_Q_DONE;
				end else if (steps_q[lvl_q]) begin
					state_d = S_Q_WAIT;
				end else if (lvl_q == LVL_W'(LEVELS - 1)) begin
					state_d = S_Q_DONE;
				end else begin
					lvl_d = lvl_q + LVL_W'(1);
				end
			end
			S_Q_WAIT: begin
				cur_d = rd_data;
				if (lvl_q == LVL_W'(LEVELS - 1)) begin
					state_d = S_Q_DONE;
				end else begin
					lvl_d   = lvl_q + LVL_W'(1);
					state_d = S_Q_STEP;
				end
			end
			S_Q_DONE: begin
				// Hold until the output register is free
				if (!out_valid_q || rsp.ready) begin
					ancestor_d  = cur_q;
					found_d     = (cur_q != '0);
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_B_RD1: begin
				rd.level = lvl_q - LVL_W'(1);
				rd.node  = j_q;
				state_d  = S_B_RD2;
			end
			S_B_RD2: begin
				rd.level = lvl_q - LVL_W'(1);
				rd.node  = rd_data;
				state_d  = S_B_WR;
			end
			S_B_WR: begin
				wr.en    = 1'b1;
				wr.level = lvl_q;
				wr.node  = j_q;
				wr.data  = rd_data;
				state_d  = S_B_RD1;
				if (j_q == last_q) begin
					j_d = NODE_W'(1);
					if (lvl_q == LVL_W'(LEVELS - 1)) begin
						state_d = S_IDLE;
					end else begin
						lvl_d = lvl_q + LVL_W'(1);
					end
				end else begin
					j_d = j_q + NODE_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
